[rtl/core/gtws_pkg.sv]
// Shared types, constants and codes for the GEMM tile wave selector.
package gtws_pkg;

  // Fixed-point score format and selection constants
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned SCORE_W   = FRAC_BITS + 1;
  localparam logic [SCORE_W-1:0] ONE_FIXED = SCORE_W'(1) << FRAC_BITS;
  localparam logic [SCORE_W:0]   SLACK_FIXED = (SCORE_W+1)'(((2 ** FRAC_BITS) + 5) / 10);
  localparam logic [31:0] WAVES_ALL_ONES = 32'hFFFF_FFFF;

  localparam int unsigned MAX_SPLIT = 16;
  localparam int unsigned SPLIT_W   = 5;
  localparam int unsigned K_LOG2    = 6;   // k tile of 64
  localparam int unsigned POS_W     = 6;   // stream positions wrap at 64

  // Field widths
  localparam int unsigned DIM_W  = 25;
  localparam int unsigned TILE_W = 9;
  localparam int unsigned STG_W  = 4;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned UNIT_W = 9;
  localparam int unsigned CPW_W  = OCC_W + UNIT_W;
  localparam int unsigned MB_W   = DIM_W;
  localparam int unsigned MBNB_W = 2 * DIM_W;
  localparam int unsigned C_W    = MBNB_W + SPLIT_W;

  // Shared divider: 56-bit dividend, 16-bit divisor, one bit a cycle
  localparam int unsigned DIV_W     = 56;
  localparam int unsigned DIVS_W    = CPW_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_K     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKSPACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONLY = 3'd6;

  typedef enum logic [2:0] {
    DIV_SEL_MB = 3'd0,
    DIV_SEL_NB = 3'd1,
    DIV_SEL_KS = 3'd2,
    DIV_SEL_C  = 3'd3,
    DIV_SEL_SC = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic [TILE_W-1:0] tile_rows;
    logic [TILE_W-1:0] tile_cols;
    logic [STG_W-1:0]  stage_count;
    logic [OCC_W-1:0]  occupancy;
    logic              last_candidate;
  } cand_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   winner_index;
    logic [TILE_W-1:0]  winner_rows;
    logic [TILE_W-1:0]  winner_cols;
    logic [SPLIT_W-1:0] winner_split;
    logic [STG_W-1:0]   winner_stages;
    logic               serial_split;
  } result_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_mb;
    logic     cap_nb;
    logic     mul;
    logic     s_init;
    logic     s_inc;
    logic     calc_c;
    logic     cap_c;
    logic     cap_sc;
    logic     update;
    logic     finish;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic s_over;
    logic weight_mode;
    logic k_misaligned;
    logic ks_fail;
    logic ws_fail;
    logic div_busy;
    logic div_done;
    logic rem_zero;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/gtws_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module gtws_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gtws_pkg::DIV_W-1:0]  dividend,
  input  logic [gtws_pkg::DIVS_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [gtws_pkg::DIV_W-1:0]  quot,
  output logic [gtws_pkg::DIVS_W-1:0] rem
);
  import gtws_pkg::*;

  logic [DIVS_W-1:0]    dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVS_W:0]      r_sh;
  logic                 fits;

  // Shift in the next dividend bit and trial-subtract
  assign r_sh = {rem, quot[DIV_W-1]};
  assign fits = r_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem  <= fits ? DIVS_W'(r_sh - {1'b0, dsr}) : r_sh[DIVS_W-1:0];
        quot <= {quot[DIV_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/gtws_ctrl.sv]
// Sequencer for candidate scoring: walks split factors over the shared divider.
module gtws_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cand_valid,
  output logic                 cand_stall,
  input  gtws_pkg::dp_status_t st,
  output gtws_pkg::dp_cmd_t    cmd
);
  import gtws_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_CHECK  = 14'b00000000000010,
    S_MB     = 14'b00000000000100,
    S_NB     = 14'b00000000001000,
    S_MUL    = 14'b00000000010000,
    S_SPLIT  = 14'b00000000100000,
    S_KS     = 14'b00000001000000,
    S_WS     = 14'b00000010000000,
    S_CSTART = 14'b00000100000000,
    S_C      = 14'b00001000000000,
    S_SC     = 14'b00010000000000,
    S_UPD    = 14'b00100000000000,
    S_NEXT   = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign cand_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode state into datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_SEL_MB;
    unique case (state)
      S_IDLE: begin
        if (cand_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.skip) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_MB;
          state_next    = S_MB;
        end
      end
      S_MB: begin
        if (st.div_done) begin
          cmd.cap_mb    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_NB;
          state_next    = S_NB;
        end
      end
      S_NB: begin
        if (st.div_done) begin
          cmd.cap_nb = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        cmd.s_init = 1'b1;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (st.s_over) begin
          state_next = S_FINISH;
        end else if (st.weight_mode) begin
          if (st.k_misaligned) begin
            state_next = S_NEXT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_KS;
            state_next    = S_KS;
          end
        end else begin
          state_next = S_WS;
        end
      end
      S_KS: begin
        if (st.div_done) begin
          state_next = st.ks_fail ? S_NEXT : S_WS;
        end
      end
      S_WS: begin
        if (st.ws_fail) begin
          state_next = S_NEXT;
        end else begin
          cmd.calc_c = 1'b1;
          state_next = S_CSTART;
        end
      end
      S_CSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_C;
        state_next    = S_C;
      end
      S_C: begin
        if (st.div_done) begin
          cmd.cap_c = 1'b1;
          if (st.rem_zero) begin
            state_next = S_UPD;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_SC;
            state_next    = S_SC;
          end
        end
      end
      S_SC: begin
        if (st.div_done) begin
          cmd.cap_sc = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.s_inc  = 1'b1;
        state_next = S_SPLIT;
      end
      S_FINISH: begin
        if (!st.last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[rtl/core/gtws_dp.sv]
// Datapath: configuration, candidate registers, scoring arithmetic, best tracking, result.
module gtws_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gtws_pkg::cand_t                      cand_data,
  input  logic                                 cfg_valid,
  input  logic [gtws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output gtws_pkg::result_t                    result_data,
  input  gtws_pkg::dp_cmd_t                    cmd,
  output gtws_pkg::dp_status_t                 st
);
  import gtws_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]   rows_m, cols_n, depth_k;
  logic [SPLIT_W-1:0] split_limit;
  logic [31:0]        workspace_size;
  logic [UNIT_W-1:0]  unit_count;
  logic               weight_only_mode;

  // Working registers
  cand_t              item;
  logic [MB_W-1:0]    mb, nb;
  logic [MBNB_W-1:0]  mbnb;
  logic [C_W-1:0]     c;
  logic [SPLIT_W-1:0] s;
  logic [31:0]        waves;
  logic [SCORE_W-1:0] score;

  // Best-so-far state
  logic [SCORE_W-1:0] best_score;
  logic [31:0]        best_waves;
  logic [TILE_W-1:0]  best_tile_rows, best_tile_cols;
  logic [SPLIT_W-1:0] best_split;
  logic [STG_W-1:0]   best_stages;
  logic [POS_W-1:0]   best_position, item_position;
  logic               have_best;

  // Divider hookup
  logic [DIV_W-1:0]  div_dividend, div_quot;
  logic [DIVS_W-1:0] div_divisor, div_rem;
  logic              div_busy, div_done;

  logic [CPW_W-1:0]   cpw;
  logic [SPLIT_W-1:0] max_s;
  logic [DIV_W:0]     waves_sum;
  logic               better, tie;

  assign cpw = CPW_W'(item.occupancy * unit_count);

  // Split range: one factor when n is wide, else the limit capped
  always_comb begin
    if (cols_n >= {8'b0, unit_count, 8'b0}) begin
      max_s = SPLIT_W'(1);
    end else if (split_limit > SPLIT_W'(MAX_SPLIT)) begin
      max_s = SPLIT_W'(MAX_SPLIT);
    end else begin
      max_s = split_limit;
    end
  end

  // Select divider operands
  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_MB: begin
        div_dividend = DIV_W'(rows_m);
        div_divisor  = DIVS_W'(item.tile_rows);
      end
      DIV_SEL_NB: begin
        div_dividend = DIV_W'(cols_n);
        div_divisor  = DIVS_W'(item.tile_cols);
      end
      DIV_SEL_KS: begin
        div_dividend = DIV_W'(depth_k);
        div_divisor  = DIVS_W'(s);
      end
      DIV_SEL_C: begin
        div_dividend = DIV_W'(c);
        div_divisor  = cpw;
      end
      DIV_SEL_SC: begin
        div_dividend = DIV_W'({DIVS_W'(cpw - div_rem), FRAC_BITS'(0)});
        div_divisor  = cpw;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  gtws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign waves_sum = {1'b0, div_quot} + (DIV_W+1)'(div_rem != '0);

  // Selection rules
  assign better = (score < best_score) ||
                  ((best_waves > waves) && ({1'b0, score} < ({1'b0, best_score} + SLACK_FIXED)));
  assign tie    = (score == best_score) &&
                  ((best_stages < item.stage_count) || (s < best_split) ||
                   (best_tile_rows < item.tile_rows));

  // Status back to the sequencer
  always_comb begin
    st.skip         = (item.occupancy == '0) || (item.tile_rows == '0) ||
                      (item.tile_cols == '0) || (cpw == '0) ||
                      (have_best && (rows_m < DIM_W'(best_tile_rows)) &&
                       (best_tile_rows < item.tile_rows));
    st.s_over       = s > max_s;
    st.weight_mode  = weight_only_mode;
    st.k_misaligned = depth_k[K_LOG2-1:0] != '0;
    st.ks_fail      = (div_rem != '0) || (div_quot[K_LOG2-1:0] != '0);
    st.ws_fail      = (s > SPLIT_W'(1)) && ({mbnb, 2'b00} > (MBNB_W+2)'(workspace_size));
    st.div_busy     = div_busy;
    st.div_done     = div_done;
    st.rem_zero     = div_rem == '0;
    st.last         = item.last_candidate;
    st.out_free     = !result_valid || !result_stall;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m           <= DIM_W'(1);
      cols_n           <= DIM_W'(1);
      depth_k          <= DIM_W'(64);
      split_limit      <= SPLIT_W'(1);
      workspace_size   <= '0;
      unit_count       <= UNIT_W'(1);
      weight_only_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_M:      rows_m           <= cfg_data[DIM_W-1:0];
        CFG_COLS_N:      cols_n           <= cfg_data[DIM_W-1:0];
        CFG_DEPTH_K:     depth_k          <= cfg_data[DIM_W-1:0];
        CFG_SPLIT_LIMIT: split_limit      <= cfg_data[SPLIT_W-1:0];
        CFG_WORKSPACE:   workspace_size   <= cfg_data;
        CFG_UNIT_COUNT:  unit_count       <= cfg_data[UNIT_W-1:0];
        CFG_WEIGHT_ONLY: weight_only_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Working arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load)   item <= cand_data;
    if (cmd.cap_mb) mb   <= div_quot[MB_W-1:0] + MB_W'(div_rem != '0);
    if (cmd.cap_nb) nb   <= div_quot[MB_W-1:0] + MB_W'(div_rem != '0);
    if (cmd.mul)    mbnb <= mb * nb;
    if (cmd.s_init) begin
      s <= SPLIT_W'(1);
    end else if (cmd.s_inc) begin
      s <= s + 1'b1;
    end
    if (cmd.calc_c) c <= C_W'(mbnb * s);
    if (cmd.cap_c) begin
      waves <= (waves_sum > (DIV_W+1)'(WAVES_ALL_ONES)) ? WAVES_ALL_ONES : waves_sum[31:0];
      score <= '0;
    end
    if (cmd.cap_sc) score <= div_quot[SCORE_W-1:0];
  end

  // Best tracking, stream position and clear on emit
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      best_score     <= ONE_FIXED;
      best_waves     <= WAVES_ALL_ONES;
      best_tile_rows <= '0;
      best_tile_cols <= '0;
      best_split     <= '0;
      best_stages    <= '0;
      best_position  <= '0;
      have_best      <= 1'b0;
      item_position  <= '0;
    end else begin
      if (cmd.update && (better || tie)) begin
        best_score     <= score;
        best_waves     <= waves;
        best_tile_rows <= item.tile_rows;
        best_tile_cols <= item.tile_cols;
        best_split     <= s;
        best_stages    <= item.stage_count;
        best_position  <= item_position;
        have_best      <= 1'b1;
      end
      if (cmd.finish) item_position <= item_position + 1'b1;
    end
  end

  // Result register: load on emit, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (have_best) begin
        result_data.found         <= 1'b1;
        result_data.winner_index  <= best_position;
        result_data.winner_rows   <= best_tile_rows;
        result_data.winner_cols   <= best_tile_cols;
        result_data.winner_split  <= best_split;
        result_data.winner_stages <= best_stages;
        result_data.serial_split  <= best_split > SPLIT_W'(1);
      end else begin
        result_data <= '0;
      end
    end
  end
endmodule

[rtl/core/gemm_tile_wave_selector.sv]
// Top level of the GEMM tile wave selector: sequencer plus scoring datapath.
//
// Channel    Direction  Handshake            Payload
// cand       in         cand_valid/stall     cand_t: tile, stages, occupancy, last flag
// result     out        result_valid/stall   result_t: found flag and winner fields
// cfg        in         cfg_valid/ready      cfg_index (3 bits), cfg_data (32 bits)
//
// A candidate does fixed work (load, block counts, setup, finish), then for each split
// factor up to three divisions on the single shared divider. A skipped candidate
// goes straight from the check to finish. cand_stall is high while a candidate is in
// work.
// Synchronous reset restores register defaults and clears the best-so-far state.
// A pending result waits in the output register; the next list's last candidate
// holds until that slot frees.
module gemm_tile_wave_selector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cand_valid,
  output logic                           cand_stall,
  input  gtws_pkg::cand_t                cand_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output gtws_pkg::result_t              result_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gtws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import gtws_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  gtws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_stall (cand_stall),
    .st         (st),
    .cmd        (cmd)
  );

  gtws_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cand_data    (cand_data),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cmd          (cmd),
    .st           (st)
  );

  // Never restart the divider mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.div_busy)
    else $error("divider started while busy");

  // Never overwrite a result still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("result overwritten");

  // After a candidate is taken, the input stalls
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cand_stall)
    else $error("candidate channel open during work");

  // Completion only ends a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> $past(st.div_busy))
    else $error("divider done without work");
endmodule
